>>> hw/rtl/lfu_pkg.sv
`default_nettype none
package lfu_pkg;

    localparam int CAPACITY    = 8;
    localparam int KEY_CHARS   = 5;
    localparam int MAX_RESULTS = 8;

    localparam int KEY_W   = 40;
    localparam int COUNT_W = 16;
    localparam int KEY_BITS = KEY_CHARS * 8;
    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int OCC_W   = $clog2(CAPACITY + 1);
    localparam int DUMP_W  = $clog2(MAX_RESULTS + 1);

    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << KEY_BITS) - KEY_W'(1));
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_PRELOAD = 2'd0,
        CMD_ACCESS  = 2'd1,
        CMD_DUMP    = 2'd2,
        CMD_NONE    = 2'd3
    } command_t;

    typedef enum logic [2:0] {
        ST_HIT        = 3'd0,
        ST_INS_FREE   = 3'd1,
        ST_INS_EVICT  = 3'd2,
        ST_PRELOADED  = 3'd3,
        ST_REJECTED   = 3'd4,
        ST_DUMP_ENTRY = 3'd5,
        ST_DUMP_EMPTY = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] initial_count;
    } in_word_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [KEY_W-1:0]   key_res;
        logic [COUNT_W-1:0] count;
        logic               last;
    } out_word_t;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] cnt;
    } entry_t;

    // ascending (count, key) order
    function automatic logic pair_less(input logic [COUNT_W-1:0] ca, input logic [KEY_W-1:0] ka,
                                       input logic [COUNT_W-1:0] cb, input logic [KEY_W-1:0] kb);
        return (ca < cb) || ((ca == cb) && (ka < kb));
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/lfu_cache_replacement.sv
// preload and access: one pass over the entry memory from accept to result word
// (one read per cycle, registered read data)
// dump: one pass per emitted entry, plus a closing pass if fewer than MAX_RESULTS are found
// one command in flight at a time; the next word is accepted
// the cycle after the result word is registered
// reset: all entries invalid, capacity_in_use = 5; entry memory is not cleared
`default_nettype none
module lfu_cache_replacement
    import lfu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_word_t  in_data,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_word_t      out_data,
    input  wire logic      cfg_we,
    input  wire logic [3:0] cfg_wdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE,
        S_FLUSH
    } state_t;

    state_t              state_reg;
    logic [3:0]          cap_reg;
    logic [CAPACITY-1:0] valid_reg;

    logic [1:0]          cmd_reg;
    logic [KEY_W-1:0]    cur_key_reg;
    logic [COUNT_W-1:0]  init_reg;

    logic [OCC_W-1:0]    issue_cnt_reg;
    logic                cmp_en_reg;
    logic [IDX_W-1:0]    cmp_idx_reg;

    logic                match_found_reg;
    logic [IDX_W-1:0]    match_idx_reg;
    logic [COUNT_W-1:0]  match_cnt_reg;

    logic                best_found_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [COUNT_W-1:0]  best_cnt_reg;
    logic [KEY_W-1:0]    best_key_reg;

    logic                have_prev_reg;
    logic [COUNT_W-1:0]  prev_cnt_reg;
    logic [KEY_W-1:0]    prev_key_reg;
    logic [DUMP_W-1:0]   dump_n_reg;

    logic                out_valid_reg;
    out_word_t           out_reg;

    entry_t              mem [CAPACITY];
    entry_t              rd_data_reg;
    logic [IDX_W-1:0]    rd_addr;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_wa;
    entry_t              mem_wd;

    logic                accept;
    logic                out_free;
    logic                emit;
    out_word_t           out_next;

    logic                ent_live;
    logic                cand;
    logic                take;
    logic                hit;
    logic                scan_last;

    logic [OCC_W-1:0]    limit;
    logic [OCC_W-1:0]    occ;
    logic                full;
    logic [IDX_W-1:0]    free_idx;
    logic [COUNT_W-1:0]  inc_cnt;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign rd_addr   = issue_cnt_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // capacity clamp, occupancy, lowest free slot and saturating hit count
    always_comb
    begin
        if (cap_reg == 4'd0)
        begin
            limit = OCC_W'(1);
        end
        else if (32'(cap_reg) > CAPACITY)
        begin
            limit = OCC_W'(CAPACITY);
        end
        else
        begin
            limit = OCC_W'(cap_reg);
        end
        occ  = OCC_W'($countones(valid_reg));
        full = (occ >= limit);
        free_idx = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        inc_cnt = (match_cnt_reg == COUNT_MAX) ? match_cnt_reg : match_cnt_reg + COUNT_W'(1);
    end

    // compare stage of the scan
    always_comb
    begin
        ent_live  = cmp_en_reg && valid_reg[cmp_idx_reg];
        hit       = ent_live && (rd_data_reg.key == cur_key_reg);
        cand      = ent_live && (!have_prev_reg ||
                    pair_less(prev_cnt_reg, prev_key_reg, rd_data_reg.cnt, rd_data_reg.key));
        take      = cand && (!best_found_reg ||
                    pair_less(rd_data_reg.cnt, rd_data_reg.key, best_cnt_reg, best_key_reg));
        scan_last = cmp_en_reg && (cmp_idx_reg == IDX_W'(CAPACITY - 1));
    end

    // finishing step of a command
    always_comb
    begin
        emit     = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = '0;
        mem_wd   = '{key: cur_key_reg, cnt: COUNT_W'(1)};
        out_next = '{status: ST_HIT, key_res: cur_key_reg, count: '0, last: 1'b1};
        if (state_reg == S_DONE && out_free)
        begin
            case (command_t'(cmd_reg))
                CMD_PRELOAD:
                begin
                    emit = 1'b1;
                    if (match_found_reg || !full)
                    begin
                        mem_we   = 1'b1;
                        mem_wa   = match_found_reg ? match_idx_reg : free_idx;
                        mem_wd   = '{key: cur_key_reg, cnt: init_reg};
                        out_next = '{status: ST_PRELOADED, key_res: cur_key_reg,
                                     count: init_reg, last: 1'b1};
                    end
                    else
                    begin
                        out_next = '{status: ST_REJECTED, key_res: cur_key_reg,
                                     count: '0, last: 1'b1};
                    end
                end
                CMD_ACCESS:
                begin
                    emit   = 1'b1;
                    mem_we = 1'b1;
                    if (match_found_reg)
                    begin
                        mem_wa   = match_idx_reg;
                        mem_wd   = '{key: cur_key_reg, cnt: inc_cnt};
                        out_next = '{status: ST_HIT, key_res: cur_key_reg,
                                     count: inc_cnt, last: 1'b1};
                    end
                    else if (!full)
                    begin
                        mem_wa   = free_idx;
                        out_next = '{status: ST_INS_FREE, key_res: cur_key_reg,
                                     count: COUNT_W'(1), last: 1'b1};
                    end
                    else
                    begin
                        mem_wa   = best_found_reg ? best_idx_reg : '0;
                        out_next = '{status: ST_INS_EVICT, key_res: best_key_reg,
                                     count: COUNT_W'(1), last: 1'b1};
                    end
                end
                CMD_DUMP:
                begin
                    // the previous pass's entry goes out once we know whether more follow
                    if (best_found_reg)
                    begin
                        emit     = have_prev_reg;
                        out_next = '{status: ST_DUMP_ENTRY, key_res: prev_key_reg,
                                     count: prev_cnt_reg, last: 1'b0};
                    end
                    else if (have_prev_reg)
                    begin
                        emit     = 1'b1;
                        out_next = '{status: ST_DUMP_ENTRY, key_res: prev_key_reg,
                                     count: prev_cnt_reg, last: 1'b1};
                    end
                    else
                    begin
                        emit     = 1'b1;
                        out_next = '{status: ST_DUMP_EMPTY, key_res: '0, count: '0, last: 1'b1};
                    end
                end
                default:
                begin
                    emit = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_FLUSH && out_free)
        begin
            emit     = 1'b1;
            out_next = '{status: ST_DUMP_ENTRY, key_res: prev_key_reg,
                         count: prev_cnt_reg, last: 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cap_reg         <= 4'd5;
            valid_reg       <= '0;
            issue_cnt_reg   <= '0;
            cmp_en_reg      <= 1'b0;
            cmp_idx_reg     <= '0;
            match_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
            have_prev_reg   <= 1'b0;
            dump_n_reg      <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end

            if (emit)
            begin
                out_reg       <= out_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (mem_we)
            begin
                valid_reg[mem_wa] <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && in_data.command != CMD_NONE)
                    begin
                        state_reg       <= S_SCAN;
                        cmd_reg         <= in_data.command;
                        cur_key_reg     <= in_data.key & KEY_MASK;
                        init_reg        <= in_data.initial_count;
                        issue_cnt_reg   <= '0;
                        cmp_en_reg      <= 1'b0;
                        match_found_reg <= 1'b0;
                        best_found_reg  <= 1'b0;
                        have_prev_reg   <= 1'b0;
                        dump_n_reg      <= '0;
                    end
                end
                S_SCAN:
                begin
                    cmp_en_reg  <= (32'(issue_cnt_reg) < CAPACITY);
                    cmp_idx_reg <= issue_cnt_reg[IDX_W-1:0];
                    if (32'(issue_cnt_reg) < CAPACITY)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + OCC_W'(1);
                    end
                    if (hit)
                    begin
                        match_found_reg <= 1'b1;
                        match_idx_reg   <= cmp_idx_reg;
                        match_cnt_reg   <= rd_data_reg.cnt;
                    end
                    if (take)
                    begin
                        best_found_reg <= 1'b1;
                        best_idx_reg   <= cmp_idx_reg;
                        best_cnt_reg   <= rd_data_reg.cnt;
                        best_key_reg   <= rd_data_reg.key;
                    end
                    if (scan_last)
                    begin
                        state_reg  <= S_DONE;
                        cmp_en_reg <= 1'b0;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        if (cmd_reg == CMD_DUMP && best_found_reg)
                        begin
                            have_prev_reg  <= 1'b1;
                            prev_cnt_reg   <= best_cnt_reg;
                            prev_key_reg   <= best_key_reg;
                            dump_n_reg     <= dump_n_reg + DUMP_W'(1);
                            best_found_reg <= 1'b0;
                            issue_cnt_reg  <= '0;
                            cmp_en_reg     <= 1'b0;
                            if (32'(dump_n_reg) + 1 >= MAX_RESULTS)
                            begin
                                state_reg <= S_FLUSH;
                            end
                            else
                            begin
                                state_reg <= S_SCAN;
                            end
                        end
                        else
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end
                S_FLUSH:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
